// ----- src/oal_pkg.sv -----
// Shared definitions for the ordered array list engine: sizes, op and status
// codes, the store access bundle and the microcode program ROM.
// No dependencies.
package oal_pkg;

    // list geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = 6;
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;
    localparam int UPC_W    = 5;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [UPC_W-1:0]  upc_t;

    // operation codes
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_END   = 3'd1;
    localparam logic [2:0] OP_INS_POS   = 3'd2;
    localparam logic [2:0] OP_DEL_FRONT = 3'd3;
    localparam logic [2:0] OP_DEL_END   = 3'd4;
    localparam logic [2:0] OP_DEL_POS   = 3'd5;
    localparam logic [2:0] OP_TRAVERSE  = 3'd6;
    localparam logic [2:0] OP_SEARCH    = 3'd7;

    // result status codes
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_BADPOS  = 3'd3;
    localparam logic [2:0] ST_ELEM    = 3'd4;
    localparam logic [2:0] ST_MATCH   = 3'd5;
    localparam logic [2:0] ST_NOMATCH = 3'd6;

    // datapath actions driven by one control word
    typedef enum logic [3:0] {
        A_NOP,
        A_PTR_CNT,
        A_PTR_POS,
        A_PTR_ZERO,
        A_RD_PREV,
        A_RD_NEXT,
        A_RD_PTR,
        A_WR_DEC,
        A_WR_INC,
        A_WR_VAL,
        A_CNT_DEC,
        A_EMIT_ELEM,
        A_CMP,
        A_FLUSH,
        A_EMIT_ST
    } act_t;

    // branch conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_FULL,
        C_INS_BAD,
        C_EMPTY,
        C_DEL_BAD,
        C_PTR_EQ_POS,
        C_PTR_LAST,
        C_PTR_EOL
    } cond_t;

    typedef struct packed {
        act_t       act;
        logic [2:0] st;
        cond_t      cond;
        upc_t       jump;
    } uword_t;

    // store access bundle
    typedef struct packed {
        logic              we;
        addr_t             waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        addr_t             raddr;
    } mem_req_t;

    // program entry points
    localparam upc_t U_IDLE  = 5'd0;
    localparam upc_t U_INS   = 5'd1;
    localparam upc_t U_INS_L = 5'd3;
    localparam upc_t U_INS_W = 5'd5;
    localparam upc_t U_DEL   = 5'd6;
    localparam upc_t U_DEL_L = 5'd8;
    localparam upc_t U_DEL_E = 5'd10;
    localparam upc_t U_TRV   = 5'd11;
    localparam upc_t U_TRV_L = 5'd12;
    localparam upc_t U_SRC   = 5'd14;
    localparam upc_t U_SRC_L = 5'd15;
    localparam upc_t U_SRC_F = 5'd17;
    localparam upc_t U_R_DN  = 5'd18;
    localparam upc_t U_R_FL  = 5'd19;
    localparam upc_t U_R_EM  = 5'd20;
    localparam upc_t U_R_BP  = 5'd21;

    // microcode program; a step falls through to the next unless its branch hits
    function automatic uword_t uc_rom(input upc_t a);
        uword_t w;
        w = '{act: A_NOP, st: ST_DONE, cond: C_ALWAYS, jump: U_IDLE};
        case (a)
            // insert: check, shift up from the top, place value
            5'd1:  w = '{act: A_PTR_CNT,   st: ST_DONE,   cond: C_FULL,       jump: U_R_FL};
            5'd2:  w = '{act: A_NOP,       st: ST_DONE,   cond: C_INS_BAD,    jump: U_R_BP};
            5'd3:  w = '{act: A_RD_PREV,   st: ST_DONE,   cond: C_PTR_EQ_POS, jump: U_INS_W};
            5'd4:  w = '{act: A_WR_DEC,    st: ST_DONE,   cond: C_ALWAYS,     jump: U_INS_L};
            5'd5:  w = '{act: A_WR_VAL,    st: ST_DONE,   cond: C_ALWAYS,     jump: U_R_DN};
            // delete: check, shift down from the position
            5'd6:  w = '{act: A_PTR_POS,   st: ST_DONE,   cond: C_EMPTY,      jump: U_R_EM};
            5'd7:  w = '{act: A_NOP,       st: ST_DONE,   cond: C_DEL_BAD,    jump: U_R_BP};
            5'd8:  w = '{act: A_RD_NEXT,   st: ST_DONE,   cond: C_PTR_LAST,   jump: U_DEL_E};
            5'd9:  w = '{act: A_WR_INC,    st: ST_DONE,   cond: C_ALWAYS,     jump: U_DEL_L};
            5'd10: w = '{act: A_CNT_DEC,   st: ST_DONE,   cond: C_ALWAYS,     jump: U_R_DN};
            // traverse
            5'd11: w = '{act: A_PTR_ZERO,  st: ST_DONE,   cond: C_EMPTY,      jump: U_R_EM};
            5'd12: w = '{act: A_RD_PTR,    st: ST_DONE,   cond: C_PTR_EOL,    jump: U_IDLE};
            5'd13: w = '{act: A_EMIT_ELEM, st: ST_ELEM,   cond: C_ALWAYS,     jump: U_TRV_L};
            // search, one match held back so the final one carries last
            5'd14: w = '{act: A_PTR_ZERO,  st: ST_DONE,   cond: C_NEVER,      jump: U_IDLE};
            5'd15: w = '{act: A_RD_PTR,    st: ST_DONE,   cond: C_PTR_EOL,    jump: U_SRC_F};
            5'd16: w = '{act: A_CMP,       st: ST_MATCH,  cond: C_ALWAYS,     jump: U_SRC_L};
            5'd17: w = '{act: A_FLUSH,     st: ST_MATCH,  cond: C_ALWAYS,     jump: U_IDLE};
            // single status results
            5'd18: w = '{act: A_EMIT_ST,   st: ST_DONE,   cond: C_ALWAYS,     jump: U_IDLE};
            5'd19: w = '{act: A_EMIT_ST,   st: ST_FULL,   cond: C_ALWAYS,     jump: U_IDLE};
            5'd20: w = '{act: A_EMIT_ST,   st: ST_EMPTY,  cond: C_ALWAYS,     jump: U_IDLE};
            5'd21: w = '{act: A_EMIT_ST,   st: ST_BADPOS, cond: C_ALWAYS,     jump: U_IDLE};
            default: w = '{act: A_NOP,     st: ST_DONE,   cond: C_ALWAYS,     jump: U_IDLE};
        endcase
        return w;
    endfunction

    // first program step for each operation
    function automatic upc_t uc_entry(input logic [2:0] op);
        upc_t e;
        case (op)
            OP_INS_FRONT, OP_INS_END, OP_INS_POS: e = U_INS;
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: e = U_DEL;
            OP_TRAVERSE:                          e = U_TRV;
            default:                              e = U_SRC;
        endcase
        return e;
    endfunction

endpackage

// ----- src/oal_store.sv -----
// List entry store: single write port, single read port with registered data.
// Depends on oal_pkg.
module oal_store
    import oal_pkg::*;
(
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/ordered_array_list_engine_unit.sv -----
// Ordered array list engine top level: microcode sequencer, pointer/count
// datapath and result register. Depends on oal_pkg and oal_store.
//
//  channel   direction  ports                                          handshake
//  -------   ---------  ---------------------------------------------  ---------------
//  s_        in         s_op, s_value, s_position                      s_valid/s_ready
//  m_        out        m_status, m_data, m_index, m_last              m_valid/m_ready
//
// One operation at a time; s_ready is high only while the sequencer is idle.
// Insert/delete move each entry with one store read, then one
// write, through the separate read and write ports. Traverse/search read each
// entry walked and take longer while m_ready is low. Errors emit one status.
// Each operation returns to the idle step, in which the next transfer is taken.
// Reset (aresetn low, synchronous) empties the list; store contents are kept.
// A held result stalls only the steps that emit; the result register frees
// in the cycle it is taken.
module ordered_array_list_engine_unit
    import oal_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_op,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic [CNT_W-1:0]         s_position,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic signed [DATA_W-1:0] m_data,
    output logic [ADDR_W-1:0]        m_index,
    output logic                     m_last
);

    localparam cnt_t CAP_C = CNT_W'(CAPACITY);

    upc_t              upc_reg, upc_next;
    cnt_t              cnt_reg, cnt_next;
    cnt_t              ptr_reg, ptr_next;
    cnt_t              pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg;
    logic              pend_v_reg, pend_v_next;
    addr_t             pend_idx_reg, pend_idx_next;

    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    logic [DATA_W-1:0] m_data_reg;
    addr_t             m_index_reg;
    logic              m_last_reg;

    uword_t            uw;
    mem_req_t          mreq;
    logic [DATA_W-1:0] rdata;
    cnt_t              ptr_p1, ptr_m1;
    logic              accept, out_free, cond_hit, emit, stall;
    logic [2:0]        e_status;
    logic [DATA_W-1:0] e_data;
    addr_t             e_index;
    logic              e_last;

    oal_store u_store (
        .aclk    (aclk),
        .req     (mreq),
        .rd_data (rdata)
    );

    assign uw       = uc_rom(upc_reg);
    assign s_ready  = (upc_reg == U_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign ptr_p1   = ptr_reg + cnt_t'(1);
    assign ptr_m1   = ptr_reg - cnt_t'(1);

    // effective position for the fixed-place ops
    always_comb begin
        case (s_op)
            OP_INS_FRONT, OP_DEL_FRONT: pos_next = '0;
            OP_INS_END:                 pos_next = cnt_reg;
            OP_DEL_END:                 pos_next = cnt_reg - cnt_t'(1);
            default:                    pos_next = s_position;
        endcase
    end

    // branch condition
    always_comb begin
        case (uw.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_FULL:       cond_hit = (cnt_reg >= CAP_C);
            C_INS_BAD:    cond_hit = (pos_reg > cnt_reg);
            C_EMPTY:      cond_hit = (cnt_reg == '0);
            C_DEL_BAD:    cond_hit = (pos_reg >= cnt_reg);
            C_PTR_EQ_POS: cond_hit = (ptr_reg <= pos_reg);
            C_PTR_LAST:   cond_hit = (ptr_p1 >= cnt_reg);
            C_PTR_EOL:    cond_hit = (ptr_reg >= cnt_reg);
            default:      cond_hit = 1'b1;
        endcase
    end

    // datapath actions
    always_comb begin
        mreq          = '0;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        pend_v_next   = pend_v_reg;
        pend_idx_next = pend_idx_reg;
        emit          = 1'b0;
        e_status      = uw.st;
        e_data        = '0;
        e_index       = '0;
        e_last        = 1'b1;
        case (uw.act)
            A_NOP: begin
            end
            A_PTR_CNT: ptr_next = cnt_reg;
            A_PTR_POS: ptr_next = pos_reg;
            A_PTR_ZERO: begin
                ptr_next    = '0;
                pend_v_next = 1'b0;
            end
            A_RD_PREV: begin
                mreq.re    = 1'b1;
                mreq.raddr = ptr_m1[ADDR_W-1:0];
            end
            A_RD_NEXT: begin
                mreq.re    = 1'b1;
                mreq.raddr = ptr_p1[ADDR_W-1:0];
            end
            A_RD_PTR: begin
                mreq.re    = 1'b1;
                mreq.raddr = ptr_reg[ADDR_W-1:0];
            end
            A_WR_DEC: begin
                mreq.we    = 1'b1;
                mreq.waddr = ptr_reg[ADDR_W-1:0];
                mreq.wdata = rdata;
                ptr_next   = ptr_m1;
            end
            A_WR_INC: begin
                mreq.we    = 1'b1;
                mreq.waddr = ptr_reg[ADDR_W-1:0];
                mreq.wdata = rdata;
                ptr_next   = ptr_p1;
            end
            A_WR_VAL: begin
                mreq.we    = 1'b1;
                mreq.waddr = pos_reg[ADDR_W-1:0];
                mreq.wdata = val_reg;
                cnt_next   = cnt_reg + cnt_t'(1);
            end
            A_CNT_DEC: cnt_next = cnt_reg - cnt_t'(1);
            A_EMIT_ELEM: begin
                emit     = 1'b1;
                e_data   = rdata;
                e_index  = ptr_reg[ADDR_W-1:0];
                e_last   = (ptr_p1 == cnt_reg);
                ptr_next = ptr_p1;
            end
            A_CMP: begin
                ptr_next = ptr_p1;
                if (rdata == val_reg) begin
                    // release the held match, hold this one
                    emit          = pend_v_reg;
                    e_data        = val_reg;
                    e_index       = pend_idx_reg;
                    e_last        = 1'b0;
                    pend_v_next   = 1'b1;
                    pend_idx_next = ptr_reg[ADDR_W-1:0];
                end
            end
            A_FLUSH: begin
                emit   = 1'b1;
                e_data = val_reg;
                if (pend_v_reg) begin
                    e_index = pend_idx_reg;
                end else begin
                    e_status = ST_NOMATCH;
                end
            end
            A_EMIT_ST: emit = 1'b1;
            default: begin
            end
        endcase
    end

    assign stall = emit && !out_free;

    // step counter
    always_comb begin
        if (accept) begin
            upc_next = uc_entry(s_op);
        end else if (stall) begin
            upc_next = upc_reg;
        end else if (cond_hit) begin
            upc_next = uw.jump;
        end else begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= U_IDLE;
            cnt_reg     <= '0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg <= upc_next;
            if (!stall) begin
                cnt_reg    <= cnt_next;
                pend_v_reg <= pend_v_next;
            end
            if (emit && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // operands, pointers and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            val_reg <= s_value;
            pos_reg <= pos_next;
        end
        if (!stall) begin
            ptr_reg      <= ptr_next;
            pend_idx_reg <= pend_idx_next;
        end
        if (emit && out_free) begin
            m_status_reg <= e_status;
            m_data_reg   <= e_data;
            m_index_reg  <= e_index;
            m_last_reg   <= e_last;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;
    assign m_index  = m_index_reg;
    assign m_last   = m_last_reg;

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CAP_C)
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(cnt_reg) |-> (cnt_reg == $past(cnt_reg) + cnt_t'(1))
                           || (cnt_reg == $past(cnt_reg) - cnt_t'(1)))
        else $error("entry count moved by more than one");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("new transfer taken while an operation runs");

    a_no_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !emit)
        else $error("result produced while sequencer idle");

endmodule

// ----- sim/oal_list_checker.sv -----
// Checker for the ordered array list engine: watches both channels, keeps a
// shadow copy of the list and compares every result transfer with its prediction.
// Depends on oal_pkg.
module oal_list_checker
    import oal_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [2:0]               s_op,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic [CNT_W-1:0]         s_position,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [2:0]               m_status,
    input  logic signed [DATA_W-1:0] m_data,
    input  logic [ADDR_W-1:0]        m_index,
    input  logic                     m_last,
    output int                       fail_count,
    output int                       pending,
    output int                       results_checked,
    output cnt_t                     list_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] data;
        addr_t                    index;
        logic                     last;
    } list_result_t;

    // shadow list and results still owed by the block
    logic signed [DATA_W-1:0] shadow_store [CAPACITY];
    cnt_t                     shadow_count;
    list_result_t             expected_results [$];

    assign list_count = shadow_count;

    initial begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
        shadow_count    = '0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] result %0d: %s", $time, results_checked, msg);
    endtask

    task automatic push_result(input logic [2:0] st, input logic signed [DATA_W-1:0] dat,
                               input int idx, input logic lst);
        list_result_t r;
        r.status = st;
        r.data   = dat;
        r.index  = addr_t'(idx);
        r.last   = lst;
        expected_results.push_back(r);
    endtask

    // insert with entries from pos upwards moved up one slot
    function automatic logic [2:0] shift_in(input int pos, input logic signed [DATA_W-1:0] val);
        if (int'(shadow_count) >= CAPACITY)
            return ST_FULL;
        if (pos > int'(shadow_count))
            return ST_BADPOS;
        for (int i = int'(shadow_count); i > pos; i--)
            shadow_store[i] = shadow_store[i-1];
        shadow_store[pos] = val;
        shadow_count++;
        return ST_DONE;
    endfunction

    // delete with later entries moved down one slot
    function automatic logic [2:0] shift_out(input int pos);
        if (shadow_count == 0)
            return ST_EMPTY;
        if (pos >= int'(shadow_count))
            return ST_BADPOS;
        for (int i = pos; i + 1 < int'(shadow_count); i++)
            shadow_store[i] = shadow_store[i+1];
        shadow_count--;
        return ST_DONE;
    endfunction

    // expected results of one accepted operation
    task automatic predict_list_op(input logic [2:0] op, input logic signed [DATA_W-1:0] val,
                                   input logic [CNT_W-1:0] pos);
        logic [2:0] st;
        int         hits;
        int         k;
        hits = 0;
        k    = 0;
        case (op)
            OP_INS_FRONT: st = shift_in(0, val);
            OP_INS_END:   st = shift_in(int'(shadow_count), val);
            OP_INS_POS:   st = shift_in(int'(pos), val);
            OP_DEL_FRONT: st = shift_out(0);
            OP_DEL_END:   st = (shadow_count == 0) ? ST_EMPTY : shift_out(int'(shadow_count) - 1);
            OP_DEL_POS:   st = shift_out(int'(pos));
            OP_TRAVERSE: begin
                if (shadow_count == 0) begin
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < int'(shadow_count); i++)
                        push_result(ST_ELEM, shadow_store[i], i, i + 1 == int'(shadow_count));
                end
                return;
            end
            default: begin
                // search: count matches first so the final one carries last
                for (int i = 0; i < int'(shadow_count); i++)
                    if (shadow_store[i] == val)
                        hits++;
                if (hits == 0) begin
                    push_result(ST_NOMATCH, val, 0, 1'b1);
                end else begin
                    for (int i = 0; i < int'(shadow_count); i++) begin
                        if (shadow_store[i] == val) begin
                            push_result(ST_MATCH, val, i, k + 1 == hits);
                            k++;
                        end
                    end
                end
                return;
            end
        endcase
        push_result(st, '0, 0, 1'b1);
    endtask

    // compare one result transfer with the oldest prediction
    task automatic check_result();
        list_result_t want;
        results_checked++;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer status %0d data %0d index %0d last %0b",
                                      m_status, m_data, m_index, m_last));
            return;
        end
        want = expected_results.pop_front();
        if (m_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", m_status, want.status));
        if (m_data !== want.data)
            report_mismatch($sformatf("data got %0d want %0d", m_data, want.data));
        if (m_index !== want.index)
            report_mismatch($sformatf("index got %0d want %0d", m_index, want.index));
        if (m_last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", m_last, want.last));
    endtask

    // results first: an operation can be taken in the cycle its predecessor's final
    // result leaves, and that result belongs to the older expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_count = '0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready)
                predict_list_op(s_op, s_value, s_position);
        end
        pending = expected_results.size();
    end

endmodule

// ----- sim/ordered_array_list_engine_unit_tb.sv -----
// Testbench top for the ordered array list engine: clock, reset, operation
// stimulus, result back-pressure, watchdog and verdict.
// Depends on oal_pkg, ordered_array_list_engine_unit and oal_list_checker.
module ordered_array_list_engine_unit_tb
    import oal_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int PHASE_ITEMS    = 20;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [2:0]               s_op;
    logic signed [DATA_W-1:0] s_value;
    logic [CNT_W-1:0]         s_position;
    logic                     m_valid;
    logic                     m_ready;
    logic [2:0]               m_status;
    logic signed [DATA_W-1:0] m_data;
    logic [ADDR_W-1:0]        m_index;
    logic                     m_last;

    int   fail_count;
    int   pending;
    int   results_checked;
    cnt_t list_count;

    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   rx_hold_req;
    int   hold_left;
    int   items_sent;
    int   stall_cycles;

    ordered_array_list_engine_unit u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_value    (s_value),
        .s_position (s_position),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_data     (m_data),
        .m_index    (m_index),
        .m_last     (m_last)
    );

    oal_list_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_value         (s_value),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_data          (m_data),
        .m_index         (m_index),
        .m_last          (m_last),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .list_count      (list_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: random stalls, or a long hold-off when the sender asks for one
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                hold_left   = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("** ordered_array_list_engine_unit: FAILED **");
        $finish;
    end

    // one operation transfer, after a random idle gap
    task automatic offer(input logic [2:0] op, input logic signed [DATA_W-1:0] val,
                         input logic [CNT_W-1:0] pos);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_value    <= val;
        s_position <= pos;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    // changed at a rising edge, read by the receiver at falling edges
    task automatic set_idle(input int tx_pct, input int rx_pct);
        @(posedge aclk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // extremes, a small pool that gives repeated matches, or anything
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:          return 32'sh7FFF_FFFF;
            1:          return 32'sh8000_0000;
            2, 3, 4, 5: return $signed($urandom_range(0, 6)) - 3;
            default:    return $signed($urandom);
        endcase
    endfunction

    function automatic logic [2:0] pick_insert();
        case ($urandom_range(0, 2))
            0:       return OP_INS_FRONT;
            1:       return OP_INS_END;
            default: return OP_INS_POS;
        endcase
    endfunction

    function automatic logic [2:0] pick_delete();
        case ($urandom_range(0, 2))
            0:       return OP_DEL_FRONT;
            1:       return OP_DEL_END;
            default: return OP_DEL_POS;
        endcase
    endfunction

    // weighted random operation; positions mostly legal for the current count
    task automatic random_item(input int ins_pct, input int del_pct);
        int               r;
        int               cnt;
        logic [2:0]       op;
        logic [CNT_W-1:0] pos;
        cnt = int'(list_count);
        r   = $urandom_range(0, 99);
        pos = CNT_W'($urandom_range(0, 127));
        if (r < ins_pct) begin
            op = pick_insert();
            if ($urandom_range(0, 99) < 85)
                pos = CNT_W'($urandom_range(0, cnt));
        end else if (r < ins_pct + del_pct) begin
            op = pick_delete();
            if (cnt > 0 && $urandom_range(0, 99) < 85)
                pos = CNT_W'($urandom_range(0, cnt - 1));
        end else if (r < ins_pct + del_pct + 10) begin
            op = OP_TRAVERSE;
        end else begin
            op = OP_SEARCH;
        end
        offer(op, pick_value(), pos);
    endtask

    // stimulus and verdict
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_op        = OP_INS_FRONT;
        s_value     = '0;
        s_position  = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b0;
        items_sent  = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        set_idle(6, 76);

        // empty list corner cases
        offer(OP_TRAVERSE, 32'sd0, 7'd0);
        offer(OP_SEARCH, 32'sd5, 7'd0);
        offer(OP_DEL_FRONT, 32'sd0, 7'd0);
        offer(OP_DEL_END, 32'sd0, 7'd0);
        offer(OP_DEL_POS, 32'sd0, 7'd0);
        offer(OP_INS_POS, 32'sd9, 7'd1);
        // build a short list with extreme values and a repeat
        offer(OP_INS_FRONT, 32'sh7FFF_FFFF, 7'd0);
        offer(OP_INS_END, 32'sh8000_0000, 7'd0);
        offer(OP_INS_POS, -32'sd1, 7'd2);
        offer(OP_INS_POS, 32'sd0, 7'd1);
        offer(OP_INS_POS, 32'sd3, 7'd127);
        offer(OP_INS_FRONT, -32'sd1, 7'd0);
        offer(OP_TRAVERSE, 32'sd0, 7'd0);
        offer(OP_SEARCH, -32'sd1, 7'd0);
        offer(OP_SEARCH, 32'sd12345, 7'd0);
        // bad positions, then every kind of delete
        offer(OP_DEL_POS, 32'sd0, 7'd5);
        offer(OP_DEL_POS, 32'sd0, 7'd127);
        offer(OP_DEL_POS, 32'sd0, 7'd2);
        offer(OP_DEL_END, 32'sd0, 7'd0);
        offer(OP_DEL_FRONT, 32'sd0, 7'd0);
        offer(OP_TRAVERSE, 32'sd0, 7'd0);
        offer(OP_SEARCH, 32'sh8000_0000, 7'd0);

        // phase one: sender mostly busy, receiver mostly stalled
        for (int i = 0; i < PHASE_ITEMS; i++)
            random_item(50, 25);

        // fill to capacity, then full inserts, full being checked before position
        while (int'(list_count) < CAPACITY)
            offer(pick_insert(), pick_value(), CNT_W'($urandom_range(0, int'(list_count))));
        offer(OP_INS_FRONT, pick_value(), 7'd0);
        offer(OP_INS_END, pick_value(), 7'd0);
        offer(OP_INS_POS, pick_value(), 7'd127);
        offer(OP_INS_POS, pick_value(), 7'd64);

        // full traverse against a long receiver hold-off while more items wait
        offer(OP_TRAVERSE, 32'sd0, 7'd0);
        rx_hold_req = 1'b1;
        offer(OP_SEARCH, pick_value(), 7'd0);
        offer(OP_DEL_POS, 32'sd0, 7'd64);
        wait_for_results();

        // phase two: sender mostly idle, receiver mostly ready
        set_idle(76, 6);
        for (int i = 0; i < PHASE_ITEMS; i++)
            random_item(35, 40);
        wait_for_results();

        // phase three: no idling, deletes favoured
        set_idle(0, 0);
        for (int i = 0; i < PHASE_ITEMS; i++)
            random_item(30, 45);
        offer(OP_DEL_END, 32'sd0, 7'd0);
        offer(OP_DEL_POS, 32'sd0, 7'd0);
        offer(OP_TRAVERSE, 32'sd0, 7'd0);
        offer(OP_SEARCH, pick_value(), 7'd0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d operations sent: empty and full list, bad positions, search with and without",
                 items_sent);
        $display("matches, long result stall; %0d result transfers checked, %0d mismatches",
                 results_checked, fail_count);
        if (fail_count == 0)
            $display("** ordered_array_list_engine_unit: PASSED **");
        else
            $display("** ordered_array_list_engine_unit: FAILED **");
        $finish;
    end

endmodule

// ----- ordered_array_list_engine_unit.f -----
src/oal_pkg.sv
src/oal_store.sv
src/ordered_array_list_engine_unit.sv
sim/oal_list_checker.sv
sim/ordered_array_list_engine_unit_tb.sv
